/* hw/rtl/okte_pkg.sv */
// shared types, codes and constants of the ordered key table engine
`timescale 1ns / 1ps
`default_nettype none
package okte_pkg;

  localparam int CAPACITY_DEFAULT = 32;

  localparam int FUNC_W   = 3;
  localparam int KEY_W    = 32;
  localparam int HANDLE_W = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 6;

  localparam int S_TDATA_W = 48;
  localparam int S_TUSER_W = 3;
  localparam int M_TDATA_W = 56;
  localparam int M_TUSER_W = 3;

  localparam logic [FUNC_W-1:0] FUNC_ADD    = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_LOOKUP = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_DELETE = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_FIRST  = 3'd3;
  localparam logic [FUNC_W-1:0] FUNC_NEXT   = 3'd4;

  localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_DUP  = 2'd2;
  localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd3;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SEARCH,
    S_SHIFT,
    S_FETCH,
    S_DONE
  } state_t;

  typedef struct packed {
    logic signed [KEY_W-1:0] key;
    logic [HANDLE_W-1:0]     handle;
  } entry_t;

  typedef struct packed {
    logic [STATUS_W-1:0]     status;
    logic                    hit;
    logic signed [KEY_W-1:0] found_key;
    logic [HANDLE_W-1:0]     found_handle;
    logic [COUNT_W-1:0]      entry_count;
  } result_t;

endpackage
`default_nettype wire

/* hw/rtl/okte_store.sv */
// entry memory: one write port, one registered read port
`timescale 1ns / 1ps
`default_nettype none
module okte_store #(
  parameter int DEPTH = okte_pkg::CAPACITY_DEFAULT,
  localparam int AW = $clog2(DEPTH)
) (
  input  wire logic             clk,
  input  wire logic             wr_en,
  input  wire logic [AW-1:0]    wr_addr,
  input  wire okte_pkg::entry_t wr_data,
  input  wire logic [AW-1:0]    rd_addr,
  output okte_pkg::entry_t      rd_data
);

  okte_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule
`default_nettype wire

/* hw/rtl/okte_ctrl.sv */
// sequencer: search, shift and cursor steps over the entry memory
`timescale 1ns / 1ps
`default_nettype none
module okte_ctrl #(
  parameter int CAPACITY = okte_pkg::CAPACITY_DEFAULT,
  localparam int AW = $clog2(CAPACITY),
  localparam int CW = $clog2(CAPACITY + 1)
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                in_valid,
  output logic                                     in_ready,
  input  wire logic [okte_pkg::FUNC_W-1:0]         in_func,
  input  wire logic signed [okte_pkg::KEY_W-1:0]   in_key,
  input  wire logic [okte_pkg::HANDLE_W-1:0]       in_handle,
  input  wire logic                                out_free,
  output logic                                     res_valid,
  output okte_pkg::result_t                        res,
  output logic                                     wr_en,
  output logic [AW-1:0]                            wr_addr,
  output okte_pkg::entry_t                         wr_data,
  output logic [AW-1:0]                            rd_addr,
  input  wire okte_pkg::entry_t                    rd_data
);

  okte_pkg::state_t state, state_next;

  logic [okte_pkg::FUNC_W-1:0]       func_r, func_r_next;
  logic signed [okte_pkg::KEY_W-1:0] key_r, key_r_next;
  logic [okte_pkg::HANDLE_W-1:0]     handle_r, handle_r_next;
  logic [AW-1:0]                     idx, idx_next;
  logic [CW-1:0]                     fill, fill_next;
  logic [CW-1:0]                     cursor, cursor_next;
  logic                              cursor_ok, cursor_ok_next;
  logic [okte_pkg::STATUS_W-1:0]     res_status, res_status_next;
  logic                              res_hit, res_hit_next;
  okte_pkg::entry_t                  res_entry, res_entry_next;

  logic [CW-1:0] idx_ext;
  logic [CW-1:0] idx_inc;
  logic [CW-1:0] cursor_adv;
  logic          match;
  logic          last;

  assign idx_ext = CW'(idx);
  assign idx_inc = idx_ext + CW'(1);
  assign match   = (idx_ext < fill) && (rd_data.key == key_r);
  assign last    = idx_inc >= fill;

  // next from the invalid cursor lands on entry 0, and it saturates at the end
  always_comb begin
    if (!cursor_ok) begin
      cursor_adv = '0;
    end else if (cursor < CW'(CAPACITY)) begin
      cursor_adv = cursor + CW'(1);
    end else begin
      cursor_adv = cursor;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= okte_pkg::S_IDLE;
      fill      <= '0;
      cursor    <= '0;
      cursor_ok <= 1'b0;
    end else begin
      state     <= state_next;
      fill      <= fill_next;
      cursor    <= cursor_next;
      cursor_ok <= cursor_ok_next;
    end
  end

  always_ff @(posedge clk) begin
    func_r     <= func_r_next;
    key_r      <= key_r_next;
    handle_r   <= handle_r_next;
    idx        <= idx_next;
    res_status <= res_status_next;
    res_hit    <= res_hit_next;
    res_entry  <= res_entry_next;
  end

  always_comb begin
    state_next      = state;
    func_r_next     = func_r;
    key_r_next      = key_r;
    handle_r_next   = handle_r;
    idx_next        = idx;
    fill_next       = fill;
    cursor_next     = cursor;
    cursor_ok_next  = cursor_ok;
    res_status_next = res_status;
    res_hit_next    = res_hit;
    res_entry_next  = res_entry;
    in_ready        = 1'b0;
    res_valid       = 1'b0;
    rd_addr         = AW'(idx_inc);
    wr_en           = 1'b0;
    wr_addr         = idx;
    wr_data         = rd_data;

    case (state)
      okte_pkg::S_IDLE: begin
        in_ready = 1'b1;
        rd_addr  = '0;
        if (in_valid) begin
          func_r_next     = in_func;
          key_r_next      = in_key;
          handle_r_next   = in_handle;
          idx_next        = '0;
          res_hit_next    = 1'b0;
          res_entry_next  = '0;
          res_status_next = okte_pkg::STATUS_NONE;
          case (in_func)
            okte_pkg::FUNC_ADD, okte_pkg::FUNC_LOOKUP, okte_pkg::FUNC_DELETE: begin
              state_next = okte_pkg::S_SEARCH;
            end
            okte_pkg::FUNC_FIRST: begin
              cursor_next    = '0;
              cursor_ok_next = 1'b1;
              state_next     = okte_pkg::S_FETCH;
            end
            okte_pkg::FUNC_NEXT: begin
              cursor_next    = cursor_adv;
              cursor_ok_next = 1'b1;
              rd_addr        = AW'(cursor_adv);
              state_next     = okte_pkg::S_FETCH;
            end
            default: begin
              state_next = okte_pkg::S_DONE;
            end
          endcase
        end
      end

      okte_pkg::S_SEARCH: begin
        if (match) begin
          cursor_next    = idx_ext;
          cursor_ok_next = 1'b1;
          state_next     = okte_pkg::S_DONE;
          case (func_r)
            okte_pkg::FUNC_LOOKUP: begin
              res_status_next = okte_pkg::STATUS_OK;
              res_hit_next    = 1'b1;
              res_entry_next  = rd_data;
            end
            okte_pkg::FUNC_DELETE: begin
              // entry idx+1 is already being read for the first move
              state_next = okte_pkg::S_SHIFT;
            end
            default: begin
              res_status_next = okte_pkg::STATUS_DUP;
            end
          endcase
        end else if (last) begin
          cursor_ok_next = 1'b0;
          state_next     = okte_pkg::S_DONE;
          if (func_r == okte_pkg::FUNC_ADD) begin
            if (fill >= CW'(CAPACITY)) begin
              res_status_next = okte_pkg::STATUS_FULL;
            end else begin
              wr_en           = 1'b1;
              wr_addr         = AW'(fill);
              wr_data.key     = key_r;
              wr_data.handle  = handle_r;
              fill_next       = fill + CW'(1);
              res_status_next = okte_pkg::STATUS_OK;
            end
          end
        end else begin
          idx_next = AW'(idx_inc);
        end
      end

      okte_pkg::S_SHIFT: begin
        rd_addr = AW'(idx_ext + CW'(2));
        if (idx_inc < fill) begin
          wr_en    = 1'b1;
          wr_addr  = idx;
          wr_data  = rd_data;
          idx_next = AW'(idx_inc);
        end else begin
          fill_next       = fill - CW'(1);
          res_status_next = okte_pkg::STATUS_OK;
          state_next      = okte_pkg::S_DONE;
        end
      end

      okte_pkg::S_FETCH: begin
        if (cursor < fill) begin
          res_status_next = okte_pkg::STATUS_OK;
          res_hit_next    = 1'b1;
          res_entry_next  = rd_data;
        end
        state_next = okte_pkg::S_DONE;
      end

      okte_pkg::S_DONE: begin
        if (out_free) begin
          res_valid  = 1'b1;
          state_next = okte_pkg::S_IDLE;
        end
      end

      default: begin
        state_next = okte_pkg::S_IDLE;
      end
    endcase
  end

  always_comb begin
    res.status       = res_status;
    res.hit          = res_hit;
    res.found_key    = res_entry.key;
    res.found_handle = res_entry.handle;
    res.entry_count  = okte_pkg::COUNT_W'(fill);
  end

endmodule
`default_nettype wire

/* hw/rtl/ordered_key_table_engine.sv */
// top level of the ordered key table engine
//
// one item on the s_ side carries an operation (s_tuser) with a key and a
// handle (s_tdata); each item gives exactly one result item on the m_ side.
// operations: add, lookup, delete, first, next over a table of up to CAPACITY
// entries kept in insertion order, with a cursor for first and next.
// steps: add, lookup and delete search the entries in order from entry 0
// until a hit or the last filled entry; delete then moves every later entry
// one place left. first and next read the entry at the cursor, other codes
// go straight to the result. the search and the move share one compare and
// one read port of the entry memory, one entry a cycle; the next item can
// be taken in the cycle after the result is registered.
// s_tready is high only while no item is in work; a finished result sits in
// the output register, and a new item may be taken while it waits.
// if m_tready stays low, the next result holds back until the register frees.
// reset empties the table and makes the cursor invalid; no clearing pass.
`timescale 1ns / 1ps
`default_nettype none
module ordered_key_table_engine #(
  parameter int CAPACITY = okte_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                             clk,
  input  wire logic                             rst,
  input  wire logic                             s_tvalid,
  output logic                                  s_tready,
  input  wire logic [okte_pkg::S_TDATA_W-1:0]   s_tdata,  // key, handle
  input  wire logic [okte_pkg::S_TUSER_W-1:0]   s_tuser,  // func
  output logic                                  m_tvalid,
  input  wire logic                             m_tready,
  output logic [okte_pkg::M_TDATA_W-1:0]        m_tdata,  // found_key, found_handle, entry_count
  output logic [okte_pkg::M_TUSER_W-1:0]        m_tuser   // status, hit
);

  localparam int AW = $clog2(CAPACITY);

  logic              out_free;
  logic              res_valid;
  okte_pkg::result_t res;
  okte_pkg::result_t out_r;
  logic              wr_en;
  logic [AW-1:0]     wr_addr;
  okte_pkg::entry_t  wr_data;
  logic [AW-1:0]     rd_addr;
  okte_pkg::entry_t  rd_data;

  assign out_free = !m_tvalid || m_tready;

  okte_ctrl #(
    .CAPACITY (CAPACITY)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_tvalid),
    .in_ready  (s_tready),
    .in_func   (s_tuser),
    .in_key    (s_tdata[okte_pkg::KEY_W-1:0]),
    .in_handle (s_tdata[okte_pkg::KEY_W+okte_pkg::HANDLE_W-1:okte_pkg::KEY_W]),
    .out_free  (out_free),
    .res_valid (res_valid),
    .res       (res),
    .wr_en     (wr_en),
    .wr_addr   (wr_addr),
    .wr_data   (wr_data),
    .rd_addr   (rd_addr),
    .rd_data   (rd_data)
  );

  okte_store #(
    .DEPTH (CAPACITY)
  ) u_store (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid) begin
      out_r <= res;
    end
  end

  assign m_tdata = {2'b00, out_r.entry_count, out_r.found_handle, out_r.found_key};
  assign m_tuser = {out_r.hit, out_r.status};

endmodule
`default_nettype wire

/* hw/rtl/okte_checker.sv */
// port checker of the ordered key table engine and its bind
`timescale 1ns / 1ps
`default_nettype none
module okte_checker (
  input wire logic                           clk,
  input wire logic                           rst,
  input wire logic                           s_tvalid,
  input wire logic                           s_tready,
  input wire logic                           m_tvalid,
  input wire logic                           m_tready,
  input wire logic [okte_pkg::M_TDATA_W-1:0] m_tdata,
  input wire logic [okte_pkg::M_TUSER_W-1:0] m_tuser
);

  // one item in work at a time
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready)
    else $error("item accepted while another is in work");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  // a returned entry always comes with status ok
  a_hit_ok: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser[2] |-> m_tuser[1:0] == okte_pkg::STATUS_OK)
    else $error("hit with failing status");

  // no entry returned means zero key and handle
  a_miss_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser[2] |-> m_tdata[47:0] == 48'd0)
    else $error("found fields set without a hit");

endmodule

bind ordered_key_table_engine okte_checker u_okte_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata),
  .m_tuser  (m_tuser)
);
`default_nettype wire
